// File: hw/rtl/kjf_pkg.sv
// Shared definitions for the jump-aware scalar Kalman filter.
// Holds default widths and the sequencer state type; no dependencies.
`timescale 1ns / 1ps

package kjf_pkg;

	// Default word width and fraction bits of the fixed-point values
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Sequencer states of the per-sample update
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ETA,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/kalman_jump_filter.sv
// Top level of the jump-aware scalar Kalman filter: sequencer, shared
// divide/accumulate step unit, state, result register and register port.
// Depends on kjf_pkg for default widths and the state type.
`timescale 1ns / 1ps

// One sample is taken at a time. A sample is taken in the idle state;
// the block then forms the error variance and next the innovation
// variance, runs the restoring gain division, one quotient bit a cycle,
// while the same steps build gain times innovation and gain times
// variance bit by bit, closes the estimate and the new error variance,
// and returns to idle to take the next sample. The result waits in an
// output register, so the next sample may be taken while it is still
// held; a sample finishes only once that register is free.
// jump_variance sits at byte address 0 (8 bytes per register when
// DATA_WIDTH exceeds 32) and resets to 1.0. A record-start sample clears
// the error variance, reports innovation 0 and takes the sample as the
// estimate; a zero innovation variance gives gain 0 and raises
// zero_variance.
module kalman_jump_filter #(
	parameter int DATA_WIDTH = kjf_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = kjf_pkg::FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// register port
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [((DATA_WIDTH > 32) ? 4 : 3)-1:0]   paddr,
	input  logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
	output logic [((DATA_WIDTH > 32) ? 64 : 32)-1:0] prdata,
	output logic                                     pready,
	// sample channel
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic signed [DATA_WIDTH-1:0]             sample,
	input  logic                                     event_req,
	input  logic [DATA_WIDTH-1:0]                    noise_variance,
	input  logic                                     record_start,
	input  logic                                     record_end,
	// result channel
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [DATA_WIDTH-1:0]             innovation,
	output logic [DATA_WIDTH-1:0]                    innovation_variance,
	output logic [FRAC_BITS:0]                       gain,
	output logic signed [DATA_WIDTH-1:0]             estimate,
	output logic                                     zero_variance,
	output logic                                     last_out
);

	localparam int DW     = DATA_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int PDW    = (DW > 32) ? 64 : 32;
	localparam int ADDR_W = (DW > 32) ? 4 : 3;
	localparam int PW     = DW + F + 1;
	localparam int CNT_W  = $clog2(F + 1);

	localparam logic [DW-1:0] ONE_FX = {{(DW-1){1'b0}}, 1'b1} << F;
	localparam logic [DW-1:0] SMAX   = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN   = {1'b1, {(DW-1){1'b0}}};

	kjf_pkg::state_t state_q, state_nx;

	logic                 in_take;
	logic                 out_take;
	logic                 done_fire;

	// register and state
	logic [DW-1:0]        jump_var_q;
	logic [DW-1:0]        err_var_q;
	logic signed [DW-1:0] prev_est_q;

	// captured sample
	logic signed [DW-1:0] sample_q;
	logic                 event_q;
	logic [DW-1:0]        noise_q;
	logic                 start_q;
	logic                 end_q;

	// working registers
	logic [DW-1:0]        var_q;
	logic [DW-1:0]        eta_q;
	logic signed [DW-1:0] innov_q;
	logic                 zero_q;
	logic [DW:0]          rem_q;
	logic [F:0]           gain_q;
	logic [PW-1:0]        acc_est_q;
	logic [DW+F-1:0]      acc_var_q;
	logic [CNT_W-1:0]     cnt_q;

	// result register
	logic                 out_valid_q;
	logic signed [DW-1:0] innovation_q;
	logic [DW-1:0]        innovation_variance_q;
	logic [F:0]           gain_out_q;
	logic signed [DW-1:0] estimate_q;
	logic                 zero_variance_q;
	logic                 last_out_q;

	// combinational datapath
	logic [DW-1:0]        var_base;
	logic [DW:0]          var_sum;
	logic [DW-1:0]        var_nx;
	logic [DW:0]          eta_sum;
	logic [DW-1:0]        eta_nx;
	logic [DW:0]          diff;
	logic [DW-1:0]        innov_nx;
	logic [DW:0]          trial;
	logic                 q_bit;
	logic [PW-1:0]        innov_x;
	logic [PW-1:0]        acc_est_nx;
	logic [DW+F-1:0]      acc_var_nx;
	logic [DW+1:0]        est_sum;
	logic [DW-1:0]        est_nx;
	logic [DW+F-1:0]      var_shrink;
	logic                 reg_write;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	// Register port: index is the bit above the byte offset
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && !paddr[ADDR_W-1];
	assign prdata    = paddr[ADDR_W-1] ? '0 : PDW'(jump_var_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_var_q <= ONE_FX;
		end else if (reg_write) begin
			jump_var_q <= pwdata[DW-1:0];
		end
	end

	// Error variance with the optional jump term, saturating
	assign var_base = start_q ? '0 : err_var_q;
	assign var_sum  = {1'b0, var_base} + {1'b0, jump_var_q};
	assign var_nx   = !event_q ? var_base : (var_sum[DW] ? '1 : var_sum[DW-1:0]);

	// Innovation variance, saturating
	assign eta_sum = {1'b0, var_q} + {1'b0, noise_q};
	assign eta_nx  = eta_sum[DW] ? '1 : eta_sum[DW-1:0];

	// Innovation, clamped to the signed word
	assign diff = {sample_q[DW-1], sample_q} - {prev_est_q[DW-1], prev_est_q};
	always_comb begin
		if (start_q) begin
			innov_nx = '0;
		end else if (diff[DW] != diff[DW-1]) begin
			innov_nx = diff[DW] ? SMIN : SMAX;
		end else begin
			innov_nx = diff[DW-1:0];
		end
	end

	// Division step, and Horner accumulation of both products on the quotient bit
	assign trial      = (cnt_q == '0) ? rem_q : {rem_q[DW-1:0], 1'b0};
	assign q_bit      = !zero_q && (trial >= {1'b0, eta_q});
	assign innov_x    = {{(F+1){innov_q[DW-1]}}, innov_q};
	assign acc_est_nx = {acc_est_q[PW-2:0], 1'b0} + (q_bit ? innov_x : '0);
	assign acc_var_nx = {acc_var_q[DW+F-2:0], 1'b0} + (q_bit ? (DW+F)'(var_q) : '0);

	// Estimate: base plus floor of gain times innovation, clamped
	assign est_sum = (start_q ? {{2{sample_q[DW-1]}}, sample_q}
	                          : {{2{prev_est_q[DW-1]}}, prev_est_q})
	               + {acc_est_q[PW-1], acc_est_q[PW-1:F]};
	always_comb begin
		if ((est_sum[DW+1:DW-1] != 3'b000) && (est_sum[DW+1:DW-1] != 3'b111)) begin
			est_nx = est_sum[DW+1] ? SMIN : SMAX;
		end else begin
			est_nx = est_sum[DW-1:0];
		end
	end

	// New error variance: var * (1 - gain), floored
	assign var_shrink = {var_q, {F{1'b0}}} - acc_var_q;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kjf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and handshake
	always_comb begin
		state_nx  = state_q;
		in_stall  = 1'b1;
		done_fire = 1'b0;
		case (state_q)
			kjf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_nx = kjf_pkg::ST_PREP;
				end
			end
			kjf_pkg::ST_PREP: begin
				state_nx = kjf_pkg::ST_ETA;
			end
			kjf_pkg::ST_ETA: begin
				state_nx = kjf_pkg::ST_DIV;
			end
			kjf_pkg::ST_DIV: begin
				if (cnt_q == CNT_W'(F)) begin
					state_nx = kjf_pkg::ST_DONE;
				end
			end
			kjf_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					done_fire = 1'b1;
					state_nx  = kjf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = kjf_pkg::ST_IDLE;
			end
		endcase
	end

	// Capture the sample on transfer
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= sample;
			event_q  <= event_req;
			noise_q  <= noise_variance;
			start_q  <= record_start;
			end_q    <= record_end;
		end
	end

	// Working registers of the shared step unit
	always_ff @(posedge clk) begin
		case (state_q)
			kjf_pkg::ST_PREP: begin
				var_q <= var_nx;
			end
			kjf_pkg::ST_ETA: begin
				eta_q     <= eta_nx;
				zero_q    <= (eta_nx == '0);
				innov_q   <= innov_nx;
				rem_q     <= {1'b0, var_q};
				gain_q    <= '0;
				acc_est_q <= '0;
				acc_var_q <= '0;
				cnt_q     <= '0;
			end
			kjf_pkg::ST_DIV: begin
				rem_q     <= q_bit ? (trial - {1'b0, eta_q}) : trial;
				gain_q    <= {gain_q[F-1:0], q_bit};
				acc_est_q <= acc_est_nx;
				acc_var_q <= acc_var_nx;
				cnt_q     <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Filter state: advance when a sample completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_var_q  <= '0;
			prev_est_q <= '0;
		end else if (done_fire) begin
			err_var_q  <= var_shrink[DW+F-1:F];
			prev_est_q <= est_nx;
		end
	end

	// Result valid: set on completion, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: load on completion, hold otherwise
	always_ff @(posedge clk) begin
		if (done_fire) begin
			innovation_q          <= innov_q;
			innovation_variance_q <= eta_q;
			gain_out_q            <= gain_q;
			estimate_q            <= est_nx;
			zero_variance_q       <= zero_q;
			last_out_q            <= end_q;
		end
	end

	assign out_valid           = out_valid_q;
	assign innovation          = innovation_q;
	assign innovation_variance = innovation_variance_q;
	assign gain                = gain_out_q;
	assign estimate            = estimate_q;
	assign zero_variance       = zero_variance_q;
	assign last_out            = last_out_q;

endmodule

// File: sim/tb_kalman_jump_filter.sv
// Self-checking testbench for kalman_jump_filter: directed table, then random records.
// Predicts untyped results with an in-bench model; depends on kjf_pkg and the RTL.
`timescale 1ns / 1ps

module tb_kalman_jump_filter;

	localparam int DW = kjf_pkg::DATA_WIDTH_DEF;
	localparam int FB = kjf_pkg::FRAC_BITS_DEF;
	localparam int PW = (DW > 32) ? 64 : 32;
	localparam int AW = (DW > 32) ? 4 : 3;
	localparam int REG_STRIDE = (DW > 32) ? 8 : 4;
	localparam int REG_JUMP_VARIANCE = 0;
	localparam int DRAIN_CYCLES = 2 * (FB + 5);
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 100;

	typedef longint unsigned u64_t;

	localparam u64_t ONE_FX = u64_t'(1) << FB;
	localparam u64_t WORD_MAX = (u64_t'(1) << DW) - 1;
	localparam longint SMAX = (longint'(1) <<< (DW - 1)) - 1;
	localparam longint SMIN = -SMAX - 1;

	typedef struct packed {
		logic signed [DW-1:0] sample;
		logic                 event_req;
		logic [DW-1:0]        noise_variance;
		logic                 record_start;
		logic                 record_end;
	} sample_item_t;

	typedef struct packed {
		logic signed [DW-1:0] innovation;
		logic [DW-1:0]        innovation_variance;
		logic [FB:0]          gain;
		logic signed [DW-1:0] estimate;
		logic                 zero_variance;
		logic                 last_out;
	} filter_result_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e      kind;
		logic [PW-1:0]  write_value;
		sample_item_t   item;
		logic           typed;
		filter_result_t want;
	} dir_row_t;

	// Block ports
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [AW-1:0]        paddr = '0;
	logic [PW-1:0]        pwdata = '0;
	logic [PW-1:0]        prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [DW-1:0] sample = '0;
	logic                 event_req = 1'b0;
	logic [DW-1:0]        noise_variance = '0;
	logic                 record_start = 1'b0;
	logic                 record_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [DW-1:0] innovation;
	logic [DW-1:0]        innovation_variance;
	logic [FB:0]          gain;
	logic signed [DW-1:0] estimate;
	logic                 zero_variance;
	logic                 last_out;

	// Filter state mirrored by the predictor
	u64_t   filt_err_var = 0;
	longint filt_prev_est = 0;
	u64_t   jump_var_shadow = ONE_FX;

	filter_result_t expected_results[$];
	int fail_count = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	int rec_left = 0;
	bit calm = 1'b0;

	kalman_jump_filter dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clamp_word(input longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	function automatic u64_t sat_sum(input u64_t a, input u64_t b);
		u64_t s;
		s = a + b;
		return (s > WORD_MAX) ? WORD_MAX : s;
	endfunction

	// Advance the filter by one sample and return the result it reports
	function automatic filter_result_t kalman_update(input sample_item_t it);
		u64_t           prior_var;
		u64_t           eta;
		u64_t           g;
		longint         innov;
		longint         base;
		longint         delta;
		longint         est;
		filter_result_t r;
		prior_var = it.record_start ? 0 : filt_err_var;
		if (it.event_req)
			prior_var = sat_sum(prior_var, jump_var_shadow);
		eta = sat_sum(prior_var, u64_t'(it.noise_variance));
		g = (eta == 0) ? 0 : (prior_var << FB) / eta;
		if (it.record_start) begin
			innov = 0;
			base = longint'($signed(it.sample));
		end else begin
			innov = clamp_word(longint'($signed(it.sample)) - filt_prev_est);
			base = filt_prev_est;
		end
		// floor of gain times innovation, for either sign
		if (innov >= 0)
			delta = longint'((u64_t'(innov) * g) >> FB);
		else
			delta = -longint'((u64_t'(-innov) * g + ONE_FX - 1) >> FB);
		est = clamp_word(base + delta);
		filt_err_var = ((prior_var * (ONE_FX - g)) >> FB) & WORD_MAX;
		filt_prev_est = est;
		r.innovation = innov[DW-1:0];
		r.innovation_variance = eta[DW-1:0];
		r.gain = g[FB:0];
		r.estimate = est[DW-1:0];
		r.zero_variance = (eta == 0);
		r.last_out = it.record_end;
		return r;
	endfunction

	function automatic void report_mismatch(input string field, input logic [63:0] want,
			input logic [63:0] got);
		$error("%s: expected %0h, got %0h", field, want, got);
		fail_count++;
	endfunction

	// Mostly short idle spells, now and then a long one
	function automatic int idle_len();
		return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 4) : $urandom_range(20, 60);
	endfunction

	function automatic dir_row_t sample_row(input logic [DW-1:0] s, input bit ev,
			input logic [DW-1:0] nv, input bit st, input bit en);
		dir_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.item.sample = s;
		r.item.event_req = ev;
		r.item.noise_variance = nv;
		r.item.record_start = st;
		r.item.record_end = en;
		return r;
	endfunction

	function automatic dir_row_t typed_row(input dir_row_t r, input logic [DW-1:0] inn,
			input logic [DW-1:0] eta, input logic [FB:0] g, input logic [DW-1:0] est,
			input bit zv);
		r.typed = 1'b1;
		r.want.innovation = inn;
		r.want.innovation_variance = eta;
		r.want.gain = g;
		r.want.estimate = est;
		r.want.zero_variance = zv;
		r.want.last_out = r.item.record_end;
		return r;
	endfunction

	function automatic dir_row_t write_row(input logic [PW-1:0] v);
		dir_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.write_value = v;
		return r;
	endfunction

	// Well-formed records with random content, plus some stray samples
	function automatic sample_item_t random_sample_item();
		sample_item_t it;
		longint       near;
		int           r;
		if ($urandom_range(0, 99) < 10) begin
			it.sample = $urandom;
			it.event_req = $urandom_range(0, 1);
			it.noise_variance = $urandom;
			it.record_start = $urandom_range(0, 1);
			it.record_end = $urandom_range(0, 1);
			return it;
		end
		it.record_start = (rec_left == 0);
		if (rec_left == 0)
			rec_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
		it.record_end = (rec_left == 1);
		rec_left--;
		it.event_req = ($urandom_range(0, 99) < 20);
		r = $urandom_range(0, 99);
		if (r < 60) begin
			near = clamp_word(filt_prev_est + longint'($urandom_range(0, 1 << 20))
				- (longint'(1) <<< 19));
			it.sample = near[DW-1:0];
		end else if (r < 80)
			it.sample = $urandom;
		else if (r < 90)
			it.sample = $urandom_range(0, 1) ? SMAX[DW-1:0] : SMIN[DW-1:0];
		else
			it.sample = DW'(longint'($urandom_range(0, 2)) - 1);
		r = $urandom_range(0, 99);
		if (r < 20)
			it.noise_variance = '0;
		else if (r < 60)
			it.noise_variance = $urandom_range(0, 1 << 18);
		else if (r < 75)
			it.noise_variance = WORD_MAX[DW-1:0] - DW'($urandom_range(0, 3));
		else
			it.noise_variance = $urandom;
		return it;
	endfunction

	// Present one sample, hold it until the transfer, then log what it should give
	task automatic send_sample(input sample_item_t it, input bit typed,
			input filter_result_t typed_want);
		filter_result_t predicted;
		@(negedge clk);
		sample <= it.sample;
		event_req <= it.event_req;
		noise_variance <= it.noise_variance;
		record_start <= it.record_start;
		record_end <= it.record_end;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = kalman_update(it);
		expected_results.push_back(typed ? typed_want : predicted);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Stop sending and wait until every result is back and the block is quiet
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_register(input int index, input logic [PW-1:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= AW'(index * REG_STRIDE);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want)
			report_mismatch("jump_variance", want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_register(input int index, input logic [PW-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'(index * REG_STRIDE);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (index == REG_JUMP_VARIANCE)
			jump_var_shadow = u64_t'(value[DW-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_register(index, value);
	endtask

	// Result side stalls in bursts unless the phase runs calm
	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 99) < 20)
				stall_left = idle_len();
		end
	end

	// Compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (innovation !== want.innovation)
					report_mismatch("innovation", want.innovation, innovation);
				if (innovation_variance !== want.innovation_variance)
					report_mismatch("innovation_variance", want.innovation_variance,
						innovation_variance);
				if (gain !== want.gain)
					report_mismatch("gain", want.gain, gain);
				if (estimate !== want.estimate)
					report_mismatch("estimate", want.estimate, estimate);
				if (zero_variance !== want.zero_variance)
					report_mismatch("zero_variance", want.zero_variance, zero_variance);
				if (last_out !== want.last_out)
					report_mismatch("last_out", want.last_out, last_out);
			end
		end
	end

	// Give up when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t      dir_rows[$];
		sample_item_t  it;
		logic [PW-1:0] phase_jump;

		// Directed rows: reset jump variance first, then the extremes
		dir_rows.push_back(typed_row(sample_row(32'h0001_0000, 0, 32'h0, 0, 0),
			32'h0001_0000, 32'h0, 17'h0, 32'h0, 1));
		dir_rows.push_back(typed_row(sample_row(32'h7FFF_FFFF, 1, 32'h0, 0, 1),
			32'h7FFF_FFFF, 32'h0001_0000, 17'h1_0000, 32'h7FFF_FFFF, 0));
		dir_rows.push_back(typed_row(sample_row(32'h8000_0000, 0, 32'hFFFF_FFFF, 0, 0),
			32'h8000_0000, 32'hFFFF_FFFF, 17'h0, 32'h7FFF_FFFF, 0));
		dir_rows.push_back(typed_row(sample_row(32'h8000_0000, 1, 32'hFFFF_FFFF, 1, 0),
			32'h0, 32'hFFFF_FFFF, 17'h1, 32'h8000_0000, 0));
		dir_rows.push_back(typed_row(sample_row(32'h7FFF_FFFF, 0, 32'h0, 0, 0),
			32'h7FFF_FFFF, 32'h0000_FFFF, 17'h1_0000, 32'hFFFF_FFFF, 0));
		dir_rows.push_back(typed_row(sample_row(32'h0, 0, 32'h0, 1, 1),
			32'h0, 32'h0, 17'h0, 32'h0, 1));
		dir_rows.push_back(sample_row(32'h0003_8000, 1, 32'h0000_8000, 0, 0));
		dir_rows.push_back(sample_row(32'hFFFE_DCBB, 1, 32'h0002_0000, 0, 0));
		dir_rows.push_back(sample_row(32'h0000_0001, 0, 32'h0000_0001, 0, 1));
		dir_rows.push_back(write_row(32'hFFFF_FFFF));
		dir_rows.push_back(typed_row(sample_row(32'h1234_5678, 1, 32'h0, 1, 0),
			32'h0, 32'hFFFF_FFFF, 17'h1_0000, 32'h1234_5678, 0));
		dir_rows.push_back(typed_row(sample_row(32'h0, 1, 32'h0000_0001, 0, 0),
			32'hEDCB_A988, 32'hFFFF_FFFF, 17'h1_0000, 32'h0, 0));
		dir_rows.push_back(write_row(32'h0));
		dir_rows.push_back(typed_row(sample_row(32'hFFFF_FFFB, 1, 32'h0, 1, 1),
			32'h0, 32'h0, 17'h0, 32'hFFFF_FFFB, 1));
		dir_rows.push_back(sample_row(32'h0, 1, 32'h0000_0001, 0, 0));
		dir_rows.push_back(write_row(32'h8000_0000));
		dir_rows.push_back(sample_row(32'h0100_0000, 1, 32'h8000_0000, 1, 0));
		dir_rows.push_back(sample_row(32'hFF00_0000, 1, 32'h4000_0000, 0, 0));
		dir_rows.push_back(sample_row(32'h0, 1, 32'h0, 0, 1));

		// Hold reset, then check the register's reset value
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		check_register(REG_JUMP_VARIANCE, PW'(ONE_FX));

		// Walk the directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				drain_results();
				write_register(REG_JUMP_VARIANCE, dir_rows[i].write_value);
			end else begin
				send_sample(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
				if ($urandom_range(0, 99) < 40)
					hold_off(idle_len());
			end
		end

		// Random phases, each under its own jump variance
		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				1: phase_jump = '0;
				2: phase_jump = WORD_MAX[PW-1:0];
				3: phase_jump = PW'($urandom_range(1, 1 << 20));
				4: phase_jump = PW'(ONE_FX);
				default: phase_jump = PW'($urandom);
			endcase
			write_register(REG_JUMP_VARIANCE, phase_jump);
			calm = (p == 4);
			rec_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// pause until the pipeline has emptied once mid-phase
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain_results();
				it = random_sample_item();
				send_sample(it, 1'b0, '0);
				if (!calm && $urandom_range(0, 99) < 40)
					hold_off(idle_len());
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
